FILE: rtl/tree_plru_block_cache_tags_core_defines.svh
// Assertion macros shared by the block cache tag controller.
`ifndef TREE_PLRU_BLOCK_CACHE_TAGS_CORE_DEFINES_SVH
`define TREE_PLRU_BLOCK_CACHE_TAGS_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TPC_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TPC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/tpc_pkg.sv
// Shared types and constants of the block cache tag controller.
`timescale 1ns / 1ps
package tpc_pkg;

  localparam int unsigned KEY_W = 64;
  localparam int unsigned IDX_W = 6;

  typedef enum logic [1:0] {
    CMD_PEEK  = 2'd0,
    CMD_STORE = 2'd1,
    CMD_QUERY = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_LOOK = 2'd1,
    ST_UPD  = 2'd2
  } state_e;

  // Controls broadcast to every line cell.
  typedef struct packed {
    logic capture;
    logic insert;
    logic or_dirty;
    logic dirty;
  } cell_ctl_t;

endpackage

FILE: rtl/tree_plru_block_cache_tags_core.sv
// Top level of the fully associative block cache tag and replacement controller.
`timescale 1ns / 1ps
`include "tree_plru_block_cache_tags_core_defines.svh"
// A command is taken when start_i is high and busy_o is low; its single result
// appears with done_o high for exactly one cycle after the ST_LOOK and ST_UPD
// states, and the receiver cannot stall it. busy_o holds off a new transaction
// until the current one is through: the request is captured when it is taken,
// every line cell compares its key in ST_LOOK, and in ST_UPD the priority
// chain through the cells picks the lowest matching line, the pseudo-LRU tree is
// walked or updated and the chosen cell is written. The result registers free the
// core, so the next transaction may be started in the same cycle that done_o is
// shown. Peek and store look up a 64-bit block key among the valid lines; a store
// miss replaces the tree pseudo-LRU victim and reports its key if it was valid and
// dirty. A query reports whether a line (index wrapped to the line count) is valid
// and dirty, with its key. Command code 3 does nothing and returns all zeros.
module tree_plru_block_cache_tags_core #(
  parameter int unsigned LINE_BITS = 6
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic [1:0]                    cmd_i,
  input  logic [tpc_pkg::KEY_W-1:0]     block_key_i,
  input  logic                          mark_dirty_i,
  input  logic [tpc_pkg::IDX_W-1:0]     query_line_i,
  output logic                          done_o,
  output logic                          hit_o,
  output logic [tpc_pkg::IDX_W-1:0]     line_index_o,
  output logic                          writeback_valid_o,
  output logic [tpc_pkg::KEY_W-1:0]     result_block_o
);

  localparam int unsigned Lines = 1 << LINE_BITS;

  tpc_pkg::state_e state_q, state_d;

  // Request captured at the start of a transaction.
  logic [1:0]                 cmd_q;
  logic [tpc_pkg::KEY_W-1:0]  key_q;
  logic                       dirty_q;
  logic [tpc_pkg::IDX_W-1:0]  qline_q;

  // Result registers.
  logic                       done_q, hit_q, wb_q;
  logic                       hit_d, wb_d;
  logic [tpc_pkg::IDX_W-1:0]  idx_q, idx_d;
  logic [tpc_pkg::KEY_W-1:0]  blk_q, blk_d;

  tpc_pkg::cell_ctl_t         ctl;
  logic [Lines-1:0]           sel;
  logic [Lines:0]             found;
  logic [Lines-1:0]           first, valid_v, dirty_v;
  logic [tpc_pkg::KEY_W-1:0]  tag_a [Lines];
  logic [LINE_BITS-1:0]       enc, victim, tgt, rd_line;
  logic                       touch;
  logic                       accept;

  assign accept = start_i && !busy_o;
  assign busy_o = (state_q != tpc_pkg::ST_IDLE);

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q   <= cmd_i;
      key_q   <= block_key_i;
      dirty_q <= mark_dirty_i;
      qline_q <= query_line_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tpc_pkg::ST_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == tpc_pkg::ST_UPD);
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == tpc_pkg::ST_UPD) begin
      hit_q <= hit_d;
      wb_q  <= wb_d;
      idx_q <= idx_d;
      blk_q <= blk_d;
    end
  end

  // The row of line cells; the found link runs from line 0 upward.
  assign found[0] = 1'b0;
  for (genvar i = 0; i < Lines; i++) begin : g_cell
    tpc_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctl_i   (ctl),
      .sel_i   (sel[i]),
      .key_i   (key_q),
      .found_i (found[i]),
      .found_o (found[i+1]),
      .first_o (first[i]),
      .tag_o   (tag_a[i]),
      .valid_o (valid_v[i]),
      .dirty_o (dirty_v[i])
    );
  end

  // Encode the one-hot first match into a line number.
  always_comb begin
    enc = '0;
    for (int i = 0; i < Lines; i++) begin
      if (first[i]) begin
        enc = enc | LINE_BITS'(i);
      end
    end
  end

  tpc_plru #(
    .LINE_BITS (LINE_BITS)
  ) u_plru (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .touch_i  (touch),
    .line_i   (tgt),
    .victim_o (victim)
  );

  assign rd_line = (cmd_q == tpc_pkg::CMD_QUERY) ? LINE_BITS'(qline_q) : victim;

  always_comb begin
    state_d     = state_q;
    ctl         = '0;
    ctl.dirty   = dirty_q;
    touch       = 1'b0;
    tgt         = found[Lines] ? enc : victim;
    hit_d       = 1'b0;
    wb_d        = 1'b0;
    idx_d       = '0;
    blk_d       = '0;
    case (state_q)
      tpc_pkg::ST_IDLE: begin
        if (start_i) state_d = tpc_pkg::ST_LOOK;
      end
      tpc_pkg::ST_LOOK: begin
        ctl.capture = 1'b1;
        state_d     = tpc_pkg::ST_UPD;
      end
      tpc_pkg::ST_UPD: begin
        state_d = tpc_pkg::ST_IDLE;
        case (cmd_q)
          tpc_pkg::CMD_PEEK: begin
            if (found[Lines]) begin
              touch        = 1'b1;
              ctl.or_dirty = 1'b1;
              hit_d        = 1'b1;
              idx_d        = tpc_pkg::IDX_W'(enc);
            end
          end
          tpc_pkg::CMD_STORE: begin
            idx_d = tpc_pkg::IDX_W'(tgt);
            if (found[Lines]) begin
              ctl.or_dirty = 1'b1;
              hit_d        = 1'b1;
            end else begin
              ctl.insert = 1'b1;
              touch      = 1'b1;
              wb_d       = valid_v[rd_line] && dirty_v[rd_line];
              blk_d      = wb_d ? tag_a[rd_line] : '0;
            end
          end
          tpc_pkg::CMD_QUERY: begin
            idx_d = tpc_pkg::IDX_W'(rd_line);
            hit_d = valid_v[rd_line] && dirty_v[rd_line];
            blk_d = hit_d ? tag_a[rd_line] : '0;
          end
          default: begin
          end
        endcase
      end
      default: state_d = tpc_pkg::ST_IDLE;
    endcase
  end

  // Only the targeted line is written.
  always_comb begin
    sel = '0;
    sel[tgt] = 1'b1;
  end

  assign done_o            = done_q;
  assign hit_o             = hit_q;
  assign line_index_o      = idx_q;
  assign writeback_valid_o = wb_q;
  assign result_block_o    = blk_q;

  `TPC_ASSERT_IMPL(a_done_follows_start, clk_i, rst_ni, done_o, $past(start_i && !busy_o, 3), "result without a started transaction")
  `TPC_ASSERT_IMPL(a_wb_on_miss, clk_i, rst_ni, writeback_valid_o && done_o, !hit_o, "write-back reported on a hit")
  `TPC_ASSERT_NEXT(a_busy_after_start, clk_i, rst_ni, start_i && !busy_o, busy_o && !done_o, "core not busy after start")
  `TPC_ASSERT_IMPL(a_one_match, clk_i, rst_ni, 1'b1, $onehot0(first), "more than one first match")

endmodule

FILE: rtl/tpc_cell.sv
// One cache line cell: key, valid and dirty marks, match flag and priority link.
`timescale 1ns / 1ps
module tpc_cell (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  tpc_pkg::cell_ctl_t         ctl_i,
  input  logic                       sel_i,
  input  logic [tpc_pkg::KEY_W-1:0]  key_i,
  input  logic                       found_i,
  output logic                       found_o,
  output logic                       first_o,
  output logic [tpc_pkg::KEY_W-1:0]  tag_o,
  output logic                       valid_o,
  output logic                       dirty_o
);

  logic [tpc_pkg::KEY_W-1:0] tag_q;
  logic                      valid_q, dirty_q, match_q;

  always_ff @(posedge clk_i) begin
    if (sel_i && ctl_i.insert) begin
      tag_q <= key_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      dirty_q <= 1'b0;
      match_q <= 1'b0;
    end else begin
      if (ctl_i.capture) begin
        match_q <= valid_q && (tag_q == key_i);
      end
      if (sel_i && ctl_i.insert) begin
        valid_q <= 1'b1;
        dirty_q <= ctl_i.dirty;
      end else if (sel_i && ctl_i.or_dirty) begin
        dirty_q <= dirty_q | ctl_i.dirty;
      end
    end
  end

  // The lowest matching line wins; the link tells later cells a match was seen.
  assign found_o = found_i | match_q;
  assign first_o = match_q & ~found_i;
  assign tag_o   = tag_q;
  assign valid_o = valid_q;
  assign dirty_o = dirty_q;

endmodule

FILE: rtl/tpc_plru.sv
// Tree pseudo-LRU state with victim walk and touch update.
`timescale 1ns / 1ps
module tpc_plru #(
  parameter int unsigned LINE_BITS = 6
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 touch_i,
  input  logic [LINE_BITS-1:0] line_i,
  output logic [LINE_BITS-1:0] victim_o
);

  localparam int unsigned Nodes = (1 << LINE_BITS) - 1;

  logic [Nodes-1:0] tree_q, tree_d;

  // Follow the tree bits from the root down to a leaf.
  always_comb begin
    logic [LINE_BITS-1:0] pre;
    logic [LINE_BITS-1:0] node;
    pre = '0;
    for (int k = 0; k < LINE_BITS; k++) begin
      node = LINE_BITS'((1 << k) - 1) + pre;
      pre  = LINE_BITS'({pre, tree_q[node]});
    end
    victim_o = pre;
  end

  // Touching a line points every node on its path away from it.
  always_comb begin
    logic [LINE_BITS-1:0] node;
    tree_d = tree_q;
    for (int k = 0; k < LINE_BITS; k++) begin
      node = LINE_BITS'((1 << k) - 1) + LINE_BITS'(line_i >> (LINE_BITS - k));
      tree_d[node] = ~line_i[LINE_BITS-1-k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tree_q <= '0;
    end else if (touch_i) begin
      tree_q <= tree_d;
    end
  end

endmodule

FILE: tb/sv/tree_plru_block_cache_tags_core_tb.sv
// Self-checking testbench for the tree pseudo-LRU block cache tag controller.
`timescale 1ns / 1ps
module tree_plru_block_cache_tags_core_tb;

  localparam int unsigned LINES = 64;
  localparam int unsigned NODES = LINES - 1;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  // One command transaction as applied to the block.
  typedef struct {
    logic [1:0]                cmd;
    logic [tpc_pkg::KEY_W-1:0] key;
    logic                      dirty;
    logic [tpc_pkg::IDX_W-1:0] qline;
  } request_t;

  // One response transaction as expected from the block.
  typedef struct {
    logic                      hit;
    logic [tpc_pkg::IDX_W-1:0] line;
    logic                      wb;
    logic [tpc_pkg::KEY_W-1:0] blk;
  } response_t;

  logic                      clk_i;
  logic                      rst_ni;
  logic                      start_i;
  logic                      busy_o;
  logic [1:0]                cmd_i;
  logic [tpc_pkg::KEY_W-1:0] block_key_i;
  logic                      mark_dirty_i;
  logic [tpc_pkg::IDX_W-1:0] query_line_i;
  logic                      done_o;
  logic                      hit_o;
  logic [tpc_pkg::IDX_W-1:0] line_index_o;
  logic                      writeback_valid_o;
  logic [tpc_pkg::KEY_W-1:0] result_block_o;

  tree_plru_block_cache_tags_core #(.LINE_BITS(6)) i_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start_i           (start_i),
    .busy_o            (busy_o),
    .cmd_i             (cmd_i),
    .block_key_i       (block_key_i),
    .mark_dirty_i      (mark_dirty_i),
    .query_line_i      (query_line_i),
    .done_o            (done_o),
    .hit_o             (hit_o),
    .line_index_o      (line_index_o),
    .writeback_valid_o (writeback_valid_o),
    .result_block_o    (result_block_o)
  );

  // The testbench's own copy of the tag store and the replacement tree.
  logic                      tree_bit [NODES];
  logic [tpc_pkg::KEY_W-1:0] tag_mem  [LINES];
  logic                      valid_mem[LINES];
  logic                      dirty_mem[LINES];

  request_t  pending_reqs[$];
  response_t expected_rsp[$];
  int        error_count;
  int        accepted_cnt;
  int        checked_cnt;
  int        wb_cnt;
  int        hit_cnt;
  bit        stimulus_done;
  int        gap_left;

  // busy_o as seen at the last rising edge, which decides whether start was taken.
  logic busy_q;

  // A pool of keys that are reused so that hits, evictions and write-backs all occur.
  logic [tpc_pkg::KEY_W-1:0] key_pool[$];

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Walks toward the least recently used leaf, flipping each bit on the way down.
  function automatic int unsigned plru_pick_victim();
    int unsigned node;
    int unsigned parent;
    node = 0;
    for (int lvl = 0; lvl < 6; lvl++) begin
      parent = node;
      node = 2 * parent + 1 + (tree_bit[parent] ? 1 : 0);
      tree_bit[parent] = ~tree_bit[parent];
    end
    return node - NODES;
  endfunction

  // Points every tree bit on the path of this line away from it.
  function automatic void plru_mark_used(int unsigned line);
    int unsigned node;
    int unsigned parent;
    node = line + NODES;
    while (node != 0) begin
      parent = (node - 1) / 2;
      tree_bit[parent] = (node == 2 * parent + 1);
      node = parent;
    end
  endfunction

  // Computes the response of one command and advances the mirrored cache state.
  function automatic response_t cache_predict(request_t rq);
    response_t   rs;
    int          found;
    int unsigned victim;
    rs = '{hit: 1'b0, line: '0, wb: 1'b0, blk: '0};
    found = -1;
    if (rq.cmd == tpc_pkg::CMD_PEEK || rq.cmd == tpc_pkg::CMD_STORE) begin
      for (int i = LINES - 1; i >= 0; i--) begin
        if (valid_mem[i] && tag_mem[i] == rq.key) found = i;
      end
    end
    case (rq.cmd)
      tpc_pkg::CMD_PEEK: begin
        if (found >= 0) begin
          plru_mark_used(found);
          dirty_mem[found] |= rq.dirty;
          rs.hit = 1'b1;
          rs.line = found[tpc_pkg::IDX_W-1:0];
        end
      end
      tpc_pkg::CMD_STORE: begin
        if (found >= 0) begin
          // A store hit leaves the replacement tree alone.
          dirty_mem[found] |= rq.dirty;
          rs.hit = 1'b1;
          rs.line = found[tpc_pkg::IDX_W-1:0];
        end else begin
          victim = plru_pick_victim();
          if (valid_mem[victim] && dirty_mem[victim]) begin
            rs.wb = 1'b1;
            rs.blk = tag_mem[victim];
          end
          tag_mem[victim] = rq.key;
          valid_mem[victim] = 1'b1;
          dirty_mem[victim] = rq.dirty;
          plru_mark_used(victim);
          rs.line = victim[tpc_pkg::IDX_W-1:0];
        end
      end
      tpc_pkg::CMD_QUERY: begin
        rs.line = rq.qline;
        if (valid_mem[rq.qline] && dirty_mem[rq.qline]) begin
          rs.hit = 1'b1;
          rs.blk = tag_mem[rq.qline];
        end
      end
      default: ;
    endcase
    return rs;
  endfunction

  function automatic logic [tpc_pkg::KEY_W-1:0] rand_key();
    return {$urandom(), $urandom()};
  endfunction

  // Mostly short gaps, now and then a long one, often none at all.
  function automatic int gap_length();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic void add_request(logic [1:0] c, logic [tpc_pkg::KEY_W-1:0] k, logic d,
                                      logic [tpc_pkg::IDX_W-1:0] q);
    request_t rq;
    rq.cmd = c;
    rq.key = k;
    rq.dirty = d;
    rq.qline = q;
    pending_reqs.push_back(rq);
  endfunction

  // Stimulus: a directed opening, then weighted random traffic over a small key pool.
  initial begin
    logic [tpc_pkg::KEY_W-1:0] k;
    int                        roll;
    int                        dir_roll;
    for (int i = 0; i < NODES; i++) tree_bit[i] = 1'b0;
    for (int i = 0; i < LINES; i++) begin
      tag_mem[i] = '1;
      valid_mem[i] = 1'b0;
      dirty_mem[i] = 1'b0;
    end
    // A peek of the all-ones key must miss, since reset tags are not valid.
    add_request(tpc_pkg::CMD_PEEK, '1, 1'b1, '0);
    add_request(tpc_pkg::CMD_PEEK, '0, 1'b0, '1);
    add_request(tpc_pkg::CMD_QUERY, '1, 1'b0, 6'd0);
    add_request(tpc_pkg::CMD_QUERY, '0, 1'b1, 6'd63);
    add_request(tpc_pkg::CMD_STORE, '1, 1'b1, '0);
    add_request(tpc_pkg::CMD_STORE, '0, 1'b0, '1);
    add_request(tpc_pkg::CMD_STORE, 64'h8000_0000_0000_0001, 1'b1, '0);
    add_request(tpc_pkg::CMD_PEEK, '1, 1'b0, '0);
    add_request(tpc_pkg::CMD_PEEK, '0, 1'b1, '0);
    add_request(tpc_pkg::CMD_STORE, '1, 1'b0, '0);
    add_request(tpc_pkg::CMD_STORE, '0, 1'b1, '0);
    add_request(tpc_pkg::CMD_QUERY, '0, 1'b0, 6'd63);
    add_request(tpc_pkg::CMD_QUERY, '0, 1'b0, 6'd32);
    add_request(tpc_pkg::CMD_QUERY, '0, 1'b0, 6'd1);
    add_request(CMD_UNUSED, '1, 1'b1, '1);
    add_request(CMD_UNUSED, 64'h5555_aaaa_5555_aaaa, 1'b0, 6'd21);
    key_pool.push_back('1);
    key_pool.push_back('0);
    for (int i = 0; i < 90; i++) key_pool.push_back(rand_key());
    for (int n = 0; n < 600; n++) begin
      roll = $urandom_range(0, 99);
      dir_roll = $urandom_range(0, 1);
      // Ninety-two keys over sixty-four lines keep evictions of dirty lines frequent.
      k = ($urandom_range(0, 9) == 0) ? rand_key() : key_pool[$urandom_range(0, 91)];
      if (roll < 45) begin
        add_request(tpc_pkg::CMD_STORE, k, dir_roll[0], tpc_pkg::IDX_W'($urandom()));
      end else if (roll < 75) begin
        add_request(tpc_pkg::CMD_PEEK, k, dir_roll[0], tpc_pkg::IDX_W'($urandom()));
      end else if (roll < 96) begin
        add_request(tpc_pkg::CMD_QUERY, rand_key(), dir_roll[0],
                    tpc_pkg::IDX_W'($urandom()));
      end else begin
        add_request(CMD_UNUSED, rand_key(), dir_roll[0], tpc_pkg::IDX_W'($urandom()));
      end
    end
  end

  // Reset and all inputs start at known values.
  initial begin
    rst_ni = 1'b0;
    start_i = 1'b0;
    cmd_i = tpc_pkg::CMD_PEEK;
    block_key_i = '0;
    mark_dirty_i = 1'b0;
    query_line_i = '0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
  end

  // Driver: at each falling edge, retire a transaction taken at the last rising
  // edge, then keep an untaken request, wait out a gap or present the next pending one.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (start_i && !busy_q) begin
        accepted_cnt <= accepted_cnt + 1;
        expected_rsp.push_back(cache_predict(pending_reqs.pop_front()));
        gap_left = gap_length();
      end
      if (start_i && busy_q) begin
        // The request is still being held; keep it on the ports.
      end else if (gap_left > 0 || pending_reqs.size() == 0) begin
        if (gap_left > 0) gap_left = gap_left - 1;
        start_i <= 1'b0;
        if (pending_reqs.size() == 0 && !(start_i && busy_q)) stimulus_done <= 1'b1;
      end else begin
        start_i <= 1'b1;
        cmd_i <= pending_reqs[0].cmd;
        block_key_i <= pending_reqs[0].key;
        mark_dirty_i <= pending_reqs[0].dirty;
        query_line_i <= pending_reqs[0].qline;
      end
    end
  end

  initial busy_q = 1'b1;
  always @(posedge clk_i) busy_q <= busy_o;

  // Monitor: compares each strobed response with the oldest expectation.
  always @(posedge clk_i) begin
    response_t ex;
    if (rst_ni && done_o) begin
      if (expected_rsp.size() == 0) begin
        $error("Response without a pending command: line %0d", line_index_o);
        error_count = error_count + 1;
      end else begin
        ex = expected_rsp.pop_front();
        checked_cnt = checked_cnt + 1;
        if (ex.wb) wb_cnt = wb_cnt + 1;
        if (ex.hit) hit_cnt = hit_cnt + 1;
        if (hit_o !== ex.hit) begin
          $error("hit: expected %0b, actual %0b", ex.hit, hit_o);
          error_count = error_count + 1;
        end
        if (line_index_o !== ex.line) begin
          $error("line_index: expected %0d, actual %0d", ex.line, line_index_o);
          error_count = error_count + 1;
        end
        if (writeback_valid_o !== ex.wb) begin
          $error("writeback_valid: expected %0b, actual %0b", ex.wb, writeback_valid_o);
          error_count = error_count + 1;
        end
        if (result_block_o !== ex.blk) begin
          $error("result_block: expected %h, actual %h", ex.blk, result_block_o);
          error_count = error_count + 1;
        end
      end
    end
  end

  initial begin
    error_count = 0;
    accepted_cnt = 0;
    checked_cnt = 0;
    wb_cnt = 0;
    hit_cnt = 0;
    stimulus_done = 1'b0;
    gap_left = 0;
  end

  // End of run: all requests issued and answered, then a short drain for strays.
  initial begin
    wait (stimulus_done && expected_rsp.size() == 0);
    repeat (10) @(posedge clk_i);
    $display("Ran %0d commands, checked %0d responses (%0d hits, %0d write-backs).",
             accepted_cnt, checked_cnt, hit_cnt, wb_cnt);
    if (error_count == 0 && expected_rsp.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog: far beyond what 616 commands with long gaps need.
  initial begin
    #2_000_000;
    $display("Timeout waiting for responses");
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
